// ===== hdl/tgs_pkg.sv =====
// Package for the trilinear grid sampler: sizes, codes, state and command types.
package tgs_pkg;

   // Grid geometry and number format
   localparam int AXIS_LOG2_MAX = 5;
   localparam int GRID_WORDS    = 32768;
   localparam int FRAC_BITS     = 16;

   localparam int NUM_AXES   = 3;
   localparam int VAL_W      = 32;                  // Q16.16 word
   localparam int DIFF_W     = VAL_W + 1;           // difference of two words
   localparam int INV_W      = 31;                  // reciprocal spacing
   localparam int MB_W       = 32;                  // second multiplier operand
   localparam int PROD_W     = 64;                  // kept product bits
   localparam int CI_W       = PROD_W - 2 * FRAC_BITS;
   localparam int TW         = FRAC_BITS + 1;       // weight, 0 .. 1.0
   localparam int LG_W       = 4;                   // log2 size field
   localparam int SIZES_W    = NUM_AXES * LG_W;
   localparam int WR_IDX_W   = 5;                   // write coordinate fields
   localparam int IDX_W      = AXIS_LOG2_MAX;       // grid index on one axis
   localparam int ADDR_W     = $clog2(GRID_WORDS);
   localparam int SUM_W      = NUM_AXES * AXIS_LOG2_MAX;
   localparam int AS_W       = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;
   localparam int CORNER_W   = 3;
   localparam int STEP_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0]   MAP_LAST    = 2'd3;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;
   localparam int CORNER_X_BIT = 0;
   localparam int CORNER_Y_BIT = 1;
   localparam int CORNER_Z_BIT = 2;

   // 1.0 in the fixed-point format
   localparam logic [TW-1:0]         ONE_T     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [INV_W-1:0]      INV_RESET = INV_W'(ONE_T);
   localparam logic [SIZES_W-1:0]    SIZES_RESET = 12'd1755;
   localparam logic signed [PROD_W-1:0] HALF_FX = 64'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [0:0] {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      AX_X,
      AX_Y,
      AX_Z
   } axis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_INV_SPACING_X,
      CSR_INV_SPACING_Y,
      CSR_INV_SPACING_Z,
      CSR_AXIS_SIZES
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_RD,
      ST_CAP,
      ST_MUL,
      ST_POST,
      ST_ROUTE
   } state_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][VAL_W-1:0] origin;
      logic [NUM_AXES-1:0][INV_W-1:0] inv_spacing;
      logic [NUM_AXES-1:0][LG_W-1:0]  lg;          // already clamped
   } cfg_type;

   typedef struct packed {
      logic                mem_wr;
      logic                sample_load;
      logic                map_mul;
      axis_type            mul_axis;
      logic                map_post;
      axis_type            post_axis;
      logic                rd_issue;
      logic [CORNER_W-1:0] corner;
      logic                cap_xa;
      logic                diff_en;
      axis_type            level;
      logic                blend_mul;
      logic                blend_post;
      logic                hold_ya;
      logic                hold_za;
      logic                out_load;
   } cmd_type;

endpackage

// ===== hdl/tgs_req_if.sv =====
// Request channel interface: write and sample words with valid/ready.
interface tgs_req_if import tgs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [WR_IDX_W-1:0]        write_i;
   logic [WR_IDX_W-1:0]        write_j;
   logic [WR_IDX_W-1:0]        write_k;
   logic signed [VAL_W-1:0]    write_value;
   logic signed [VAL_W-1:0]    point_x;
   logic signed [VAL_W-1:0]    point_y;
   logic signed [VAL_W-1:0]    point_z;

   modport source (
      output valid, func, write_i, write_j, write_k, write_value,
             point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, func, write_i, write_j, write_k, write_value,
             point_x, point_y, point_z,
      output ready
   );
endinterface

// ===== hdl/tgs_rsp_if.sv =====
// Response channel interface: interpolated sample words with valid/ready.
interface tgs_rsp_if import tgs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] sample_value;

   modport source (output valid, sample_value, input ready);
   modport sink   (input valid, sample_value, output ready);
endinterface

// ===== hdl/trilinear_grid_sampler.sv =====
// Top level of the trilinear grid sampler: channels, configuration port and sequencer.
//
//  channel   direction  handshake          word
//  req_chan  in         valid/ready        func, write_i/j/k, write_value, point_x/y/z
//  rsp_chan  out        valid/ready        sample_value
//  csr_*     in         csr_wr_en strobe   csr_index, csr_wr_data (no read-back)
//
//  For a write word req_chan.ready stays high and the grid memory is written on
//  the accepting edge. A sample word holds the block while it is accepted, while
//  the axes are mapped on the shared multiplier, through the eight corner reads on
//  the single memory read port, and through the seven blends on the same multiplier.
//  Reset is synchronous and clears the sequencer, the output valid and the
//  configuration registers; grid contents stay undefined until written and no
//  clearing pass runs.
//  A finished sum waits in the output register while rsp_chan is stalled, and a
//  new word may be accepted meanwhile; a second sum waits in the sequencer.
module trilinear_grid_sampler import tgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tgs_req_if.sink               req_chan,
   tgs_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type cfg;
   cmd_type cmd;

   // register file; writes must arrive only while the block is idle, which the block does not enforce
   tgs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // sequencer: one sample at a time, corners visited in x, y, z bit order
   tgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // grid memory, multiplier and the blend chain
   tgs_dp u_dp (
      .clock        (clock),
      .cfg          (cfg),
      .cmd          (cmd),
      .write_i      (req_chan.write_i),
      .write_j      (req_chan.write_j),
      .write_k      (req_chan.write_k),
      .write_value  (req_chan.write_value),
      .point_x      (req_chan.point_x),
      .point_y      (req_chan.point_y),
      .point_z      (req_chan.point_z),
      .sample_value (rsp_chan.sample_value)
   );

endmodule

// ===== hdl/tgs_csr.sv =====
// Configuration registers of the sampler: origins, reciprocal spacings, axis sizes.
module tgs_csr import tgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   logic [NUM_AXES-1:0][VAL_W-1:0] origin_ff, origin_in;
   logic [NUM_AXES-1:0][INV_W-1:0] inv_ff, inv_in;
   logic [SIZES_W-1:0]             sizes_ff, sizes_in;
   logic [LG_W-1:0]                lg_raw;

   always_comb begin
      origin_in = origin_ff;
      inv_in    = inv_ff;
      sizes_in  = sizes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      origin_in[AX_X] = csr_wr_data[VAL_W-1:0];
            CSR_ORIGIN_Y:      origin_in[AX_Y] = csr_wr_data[VAL_W-1:0];
            CSR_ORIGIN_Z:      origin_in[AX_Z] = csr_wr_data[VAL_W-1:0];
            CSR_INV_SPACING_X: inv_in[AX_X]    = csr_wr_data[INV_W-1:0];
            CSR_INV_SPACING_Y: inv_in[AX_Y]    = csr_wr_data[INV_W-1:0];
            CSR_INV_SPACING_Z: inv_in[AX_Z]    = csr_wr_data[INV_W-1:0];
            CSR_AXIS_SIZES:    sizes_in        = csr_wr_data[SIZES_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         inv_ff    <= {NUM_AXES{INV_RESET}};
         sizes_ff  <= SIZES_RESET;
      end else begin
         origin_ff <= origin_in;
         inv_ff    <= inv_in;
         sizes_ff  <= sizes_in;
      end
   end

   // sizes above the maximum saturate
   always_comb begin
      lg_raw = '0;
      cfg.origin      = origin_ff;
      cfg.inv_spacing = inv_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         lg_raw = sizes_ff[a*LG_W +: LG_W];
         cfg.lg[a] = (lg_raw > LG_W'(AXIS_LOG2_MAX)) ? LG_W'(AXIS_LOG2_MAX) : lg_raw;
      end
   end

endmodule

// ===== hdl/tgs_ctrl.sv =====
// Sequencer of the sampler: accepts words, steps the datapath, owns the response valid.
module tgs_ctrl import tgs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   axis_type            level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         corner_ff    <= '0;
         level_ff     <= AX_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         corner_ff    <= corner_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      corner_in  = corner_ff;
      level_in   = level_ff;
      cmd        = '0;
      cmd.corner = corner_ff;
      cmd.level  = level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_SAMPLE) begin
                  cmd.sample_load = 1'b1;
                  step_in         = '0;
                  state_in        = ST_MAP;
               end else begin
                  cmd.mem_wr = 1'b1;
               end
            end
         end
         ST_MAP: begin
            // multiply axis n while the product of axis n-1 is decoded
            cmd.map_mul   = (step_ff != MAP_LAST);
            cmd.mul_axis  = axis_type'(step_ff);
            cmd.map_post  = (step_ff != '0);
            cmd.post_axis = axis_type'(step_ff - 1'b1);
            if (step_ff == MAP_LAST) begin
               corner_in = '0;
               state_in  = ST_RD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CAP;
         end
         ST_CAP: begin
            if (!corner_ff[CORNER_X_BIT]) begin
               cmd.cap_xa = 1'b1;
               corner_in  = corner_ff + 1'b1;
               state_in   = ST_RD;
            end else begin
               cmd.diff_en = 1'b1;
               cmd.level   = AX_X;
               level_in    = AX_X;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.blend_mul = 1'b1;
            state_in      = ST_POST;
         end
         ST_POST: begin
            cmd.blend_post = 1'b1;
            state_in       = ST_ROUTE;
         end
         ST_ROUTE: begin
            unique case (level_ff)
               AX_X: begin
                  if (!corner_ff[CORNER_Y_BIT]) begin
                     cmd.hold_ya = 1'b1;
                     corner_in   = corner_ff + 1'b1;
                     state_in    = ST_RD;
                  end else begin
                     cmd.diff_en = 1'b1;
                     cmd.level   = AX_Y;
                     level_in    = AX_Y;
                     state_in    = ST_MUL;
                  end
               end
               AX_Y: begin
                  if (!corner_ff[CORNER_Z_BIT]) begin
                     cmd.hold_za = 1'b1;
                     corner_in   = corner_ff + 1'b1;
                     state_in    = ST_RD;
                  end else begin
                     cmd.diff_en = 1'b1;
                     cmd.level   = AX_Z;
                     level_in    = AX_Z;
                     state_in    = ST_MUL;
                  end
               end
               AX_Z: begin
                  // hold the finished sum until the output register frees up
                  if (!rsp_valid_ff || rsp_ready) begin
                     cmd.out_load = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign req_ready    = (state_ff == ST_IDLE);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a word not yet taken");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_func == FUNC_SAMPLE)
      |=> (state_ff == ST_MAP && step_ff == '0))
      else $error("sample word did not start the mapping pass");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUTE && level_ff == AX_Z) |-> (corner_ff == CORNER_LAST))
      else $error("final blend before all eight corners were read");

endmodule

// ===== hdl/tgs_dp.sv =====
// Datapath of the sampler: grid memory, shared multiplier, axis mapping and blend registers.
module tgs_dp import tgs_pkg::*; (
   input  logic                clock,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   input  logic [WR_IDX_W-1:0] write_i,
   input  logic [WR_IDX_W-1:0] write_j,
   input  logic [WR_IDX_W-1:0] write_k,
   input  logic [VAL_W-1:0]    write_value,
   input  logic [VAL_W-1:0]    point_x,
   input  logic [VAL_W-1:0]    point_y,
   input  logic [VAL_W-1:0]    point_z,
   output logic [VAL_W-1:0]    sample_value
);

   function automatic logic [ADDR_W-1:0] grid_addr(
      input logic [IDX_W-1:0] i,
      input logic [IDX_W-1:0] j,
      input logic [IDX_W-1:0] k,
      input logic [LG_W-1:0]  lx,
      input logic [LG_W-1:0]  ly
   );
      logic [LG_W:0] sh;
      logic [AS_W-1:0] sum;
      sh  = (LG_W+1)'(lx) + (LG_W+1)'(ly);
      sum = AS_W'(i) + (AS_W'(j) << lx) + (AS_W'(k) << sh);
      return ADDR_W'(sum);
   endfunction

   function automatic logic [IDX_W-1:0] dim_minus1(input logic [LG_W-1:0] lg);
      logic [IDX_W:0] d;
      d = ((IDX_W+1)'(1) << lg) - (IDX_W+1)'(1);
      return d[IDX_W-1:0];
   endfunction

   logic [VAL_W-1:0]         grid_mem [GRID_WORDS];
   logic [VAL_W-1:0]         rd_ff;
   logic signed [DIFF_W-1:0] pdiff_ff [NUM_AXES];
   logic [IDX_W-1:0]         lo_ff [NUM_AXES];
   logic [IDX_W-1:0]         hi_ff [NUM_AXES];
   logic [TW-1:0]            t_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DIFF_W-1:0] bdiff_ff;
   logic [VAL_W-1:0]         ba_ff, xa_ff, ya_ff, za_ff, res_ff, out_ff;

   logic [VAL_W-1:0]         points [NUM_AXES];
   logic                     wr_in_range;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [IDX_W-1:0]         ci, cj, ck;

   logic signed [DIFF_W-1:0]      mul_a;
   logic signed [MB_W-1:0]        mul_b;
   logic signed [DIFF_W+MB_W-1:0] mul_full;

   logic [LG_W-1:0]  lg_p;
   logic [IDX_W-1:0] dm1, lo_in, hi_in;
   logic [TW-1:0]    t_in;
   logic [CI_W-1:0]  coord_int;

   logic [VAL_W-1:0]         a_sel, b_sel;
   logic signed [PROD_W-1:0] rnd;

   assign points[AX_X] = point_x;
   assign points[AX_Y] = point_y;
   assign points[AX_Z] = point_z;

   // grid writes; coordinates past the configured size are dropped
   assign wr_in_range = ((write_i >> cfg.lg[AX_X]) == '0) &&
                        ((write_j >> cfg.lg[AX_Y]) == '0) &&
                        ((write_k >> cfg.lg[AX_Z]) == '0);
   assign wr_addr = grid_addr(IDX_W'(write_i), IDX_W'(write_j), IDX_W'(write_k),
                              cfg.lg[AX_X], cfg.lg[AX_Y]);

   // corner n takes the upper index on an axis where its bit is set
   assign ci = cmd.corner[CORNER_X_BIT] ? hi_ff[AX_X] : lo_ff[AX_X];
   assign cj = cmd.corner[CORNER_Y_BIT] ? hi_ff[AX_Y] : lo_ff[AX_Y];
   assign ck = cmd.corner[CORNER_Z_BIT] ? hi_ff[AX_Z] : lo_ff[AX_Z];
   assign rd_addr = grid_addr(ci, cj, ck, cfg.lg[AX_X], cfg.lg[AX_Y]);

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_in_range) begin
         grid_mem[wr_addr] <= write_value;
      end
      if (cmd.rd_issue) begin
         rd_ff <= grid_mem[rd_addr];
      end
   end

   // one multiplier: point offset times reciprocal spacing, or delta times weight
   always_comb begin
      if (cmd.map_mul) begin
         mul_a = pdiff_ff[cmd.mul_axis];
         mul_b = signed'(MB_W'(cfg.inv_spacing[cmd.mul_axis]));
      end else begin
         mul_a = bdiff_ff;
         mul_b = signed'(MB_W'(t_ff[cmd.level]));
      end
      mul_full = mul_a * mul_b;
   end

   // product to lower index and weight: negative -> 0, top edge -> dim-2 with weight 1.0
   always_comb begin
      lg_p      = cfg.lg[cmd.post_axis];
      dm1       = dim_minus1(lg_p);
      coord_int = prod_ff[PROD_W-1:2*FRAC_BITS];
      if (lg_p == '0 || prod_ff[PROD_W-1]) begin
         lo_in = '0;
         t_in  = '0;
      end else if (coord_int >= CI_W'(dm1)) begin
         lo_in = dm1 - 1'b1;
         t_in  = ONE_T;
      end else begin
         lo_in = coord_int[IDX_W-1:0];
         t_in  = {1'b0, prod_ff[2*FRAC_BITS-1:FRAC_BITS]};
      end
      hi_in = (lg_p == '0) ? '0 : lo_in + 1'b1;
   end

   always_comb begin
      unique case (cmd.level)
         AX_X:    a_sel = xa_ff;
         AX_Y:    a_sel = ya_ff;
         default: a_sel = za_ff;
      endcase
      b_sel = (cmd.level == AX_X) ? rd_ff : res_ff;
      rnd   = (prod_ff + HALF_FX) >>> FRAC_BITS;   // round half up
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            pdiff_ff[a] <= signed'({points[a][VAL_W-1], points[a]}) -
                           signed'({cfg.origin[a][VAL_W-1], cfg.origin[a]});
         end
      end
      if (cmd.map_mul || cmd.blend_mul) begin
         prod_ff <= mul_full[PROD_W-1:0];
      end
      if (cmd.map_post) begin
         lo_ff[cmd.post_axis] <= lo_in;
         hi_ff[cmd.post_axis] <= hi_in;
         t_ff[cmd.post_axis]  <= t_in;
      end
      if (cmd.diff_en) begin
         bdiff_ff <= signed'({b_sel[VAL_W-1], b_sel}) - signed'({a_sel[VAL_W-1], a_sel});
         ba_ff    <= a_sel;
      end
      if (cmd.blend_post) begin
         res_ff <= ba_ff + rnd[VAL_W-1:0];
      end
      if (cmd.cap_xa) begin
         xa_ff <= rd_ff;
      end
      if (cmd.hold_ya) begin
         ya_ff <= res_ff;
      end
      if (cmd.hold_za) begin
         za_ff <= res_ff;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   assign sample_value = out_ff;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the trilinear grid sampler: directed and random words, local predictor.
module tb_top;
   import tgs_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int WORD_TARGET   = 450;      // request words before the random part stops
   localparam int SETTLE_CYCLES = 48;       // longer than a sample holds the block
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_OFF      = 400;      // long response stall for the pressure test

   // index 7 decodes to nothing in the block
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   localparam logic [VAL_W-1:0] Q_ONE  = 32'h0001_0000;    // 1.0 in Q16.16
   localparam logic [VAL_W-1:0] Q_MAXV = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] Q_MINV = 32'h8000_0000;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // one request word as the bench sees it
   typedef struct packed {
      func_type            func;
      logic [WR_IDX_W-1:0] wr_i;
      logic [WR_IDX_W-1:0] wr_j;
      logic [WR_IDX_W-1:0] wr_k;
      logic [VAL_W-1:0]    wr_value;
      logic [VAL_W-1:0]    pt_x;
      logic [VAL_W-1:0]    pt_y;
      logic [VAL_W-1:0]    pt_z;
   } grid_word_type;

   // lower/upper corner index and blend weight on one axis
   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      logic [TW-1:0]    wt;
   } axis_pos_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tgs_req_if req_chan ();
   tgs_rsp_if rsp_chan ();

   trilinear_grid_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: our own copy of the grid memory and of the registers.
   // grid_written marks addresses that hold a value, so no sample ever reads an
   // entry the block has never been given.
   // ---------------------------------------------------------------------------
   logic signed [VAL_W-1:0] grid_mem     [GRID_WORDS];
   bit                      grid_written [GRID_WORDS];
   logic signed [VAL_W-1:0] cfg_origin   [NUM_AXES];
   logic [INV_W-1:0]        cfg_inv      [NUM_AXES];
   logic [SIZES_W-1:0]      cfg_sizes;

   logic signed [VAL_W-1:0] pending_samples [$];   // sums still owed by the block
   logic signed [VAL_W-1:0] expected_word;

   int errors;
   int words_sent;
   int cycle_count;
   int hold_off_len;
   bit source_steady;   // sender offers back to back
   bit sink_steady;     // receiver never stalls

   always #HALF_PERIOD clock = ~clock;

   // log2 size of one axis, clamped the way the block clamps it
   function automatic int axis_lg(input int ax);
      int lg;
      lg = int'(cfg_sizes[ax*LG_W +: LG_W]);
      return (lg > AXIS_LOG2_MAX) ? AXIS_LOG2_MAX : lg;
   endfunction

   function automatic int grid_addr(input int i, input int j, input int k);
      return (i + (j << axis_lg(0)) + (k << (axis_lg(0) + axis_lg(1)))) % GRID_WORDS;
   endfunction

   function automatic longint grid_at(input int i, input int j, input int k);
      return longint'(grid_mem[grid_addr(i, j, k)]);
   endfunction

   // Point to cell units: (p - origin) * inv_spacing carries 32 fraction bits,
   // negative pins to 0, then truncate to 16 fraction bits and clamp to dim-1.
   // The lower index stops at dim-2 so the top edge gets weight 1.0.
   function automatic axis_pos_type map_axis(input int ax, input logic signed [VAL_W-1:0] p);
      axis_pos_type pos;
      int           lg;
      longint       dim;
      longint       prod;
      longint       coord;
      longint       idx;
      pos = '0;
      lg  = axis_lg(ax);
      if (lg == 0) begin
         return pos;   // axis of size one: index 0, weight 0
      end
      dim   = longint'(1) << lg;
      prod  = (longint'(p) - longint'(cfg_origin[ax])) * longint'({1'b0, cfg_inv[ax]});
      coord = (prod < 0) ? 0 : (prod >>> FRAC_BITS);
      if (coord > ((dim - 1) <<< FRAC_BITS)) begin
         coord = (dim - 1) <<< FRAC_BITS;
      end
      idx = coord >>> FRAC_BITS;
      if (idx > dim - 2) begin
         idx = dim - 2;
      end
      pos.lo = IDX_W'(idx);
      pos.hi = IDX_W'(idx + 1);
      pos.wt = TW'(coord - (idx <<< FRAC_BITS));
      return pos;
   endfunction

   // a + round-half-up((b - a) * t / 1.0); >>> on a signed longint floors
   function automatic longint blend(input longint a, input longint b, input longint t);
      return a + (((b - a) * t + longint'(HALF_FX)) >>> FRAC_BITS);
   endfunction

   // x first, then y, then z
   function automatic logic signed [VAL_W-1:0] interp_sample(input grid_word_type w);
      axis_pos_type px;
      axis_pos_type py;
      axis_pos_type pz;
      longint       row   [2];
      longint       plane [2];
      int           jj;
      int           kk;
      px = map_axis(0, w.pt_x);
      py = map_axis(1, w.pt_y);
      pz = map_axis(2, w.pt_z);
      for (int dz = 0; dz < 2; dz++) begin
         kk = dz ? pz.hi : pz.lo;
         for (int dy = 0; dy < 2; dy++) begin
            jj = dy ? py.hi : py.lo;
            row[dy] = blend(grid_at(px.lo, jj, kk), grid_at(px.hi, jj, kk), px.wt);
         end
         plane[dz] = blend(row[0], row[1], py.wt);
      end
      return VAL_W'(blend(plane[0], plane[1], pz.wt));
   endfunction

   // Update the predictor for one accepted word. Writes outside the grid are
   // dropped; a sample queues the sum the block owes us.
   function automatic void apply_word(input grid_word_type w);
      int addr;
      if (w.func == FUNC_WRITE) begin
         if ((w.wr_i >> axis_lg(0)) == 0 && (w.wr_j >> axis_lg(1)) == 0 &&
             (w.wr_k >> axis_lg(2)) == 0) begin
            addr = grid_addr(w.wr_i, w.wr_j, w.wr_k);
            grid_mem[addr]     = w.wr_value;
            grid_written[addr] = 1'b1;
         end
      end else begin
         pending_samples = {pending_samples, interp_sample(w)};
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return Q_MAXV;
         1:       return Q_MINV;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Point coordinate that lands between one cell below the grid and one past
   // it, now and then on a whole cell; one in ten is raw noise.
   function automatic logic [VAL_W-1:0] rand_coord(input int ax);
      longint cell_pos;
      longint off;
      longint p;
      int     dim;
      if ($urandom_range(0, 9) == 0) begin
         return $urandom();
      end
      dim      = 1 << axis_lg(ax);
      cell_pos = longint'($urandom_range(0, (dim + 2) << FRAC_BITS)) -
                 (longint'(1) << FRAC_BITS);
      if ($urandom_range(0, 3) == 0) begin
         cell_pos = (cell_pos >>> FRAC_BITS) <<< FRAC_BITS;
      end
      off = (cfg_inv[ax] == 0) ? cell_pos :
            (cell_pos <<< FRAC_BITS) / longint'({1'b0, cfg_inv[ax]});
      p = longint'(cfg_origin[ax]) + off;
      if (p > Q_MAX) begin
         p = Q_MAX;
      end
      if (p < Q_MIN) begin
         p = Q_MIN;
      end
      return VAL_W'(p);
   endfunction

   // small grids most of the time, clamped oversize fields now and then
   function automatic logic [SIZES_W-1:0] rand_sizes();
      logic [SIZES_W-1:0] s;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         s[ax*LG_W +: LG_W] = ($urandom_range(0, 9) == 0) ? LG_W'($urandom_range(4, 15)) :
                                                           LG_W'($urandom_range(0, 3));
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; ready is looked at on the
   // rising edge. valid stays high into the next word unless a gap is taken.
   // ---------------------------------------------------------------------------
   task automatic send_word(input grid_word_type w);
      int gap;
      gap = (!source_steady && $urandom_range(0, 1) == 1) ? gap_len() : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.func        = w.func;
      req_chan.write_i     = w.wr_i;
      req_chan.write_j     = w.wr_j;
      req_chan.write_k     = w.wr_k;
      req_chan.write_value = w.wr_value;
      req_chan.point_x     = w.pt_x;
      req_chan.point_y     = w.pt_y;
      req_chan.point_z     = w.pt_z;
      req_chan.valid       = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic store_value(input int i, input int j, input int k,
                              input logic [VAL_W-1:0] value);
      grid_word_type w;
      w.func     = FUNC_WRITE;
      w.wr_i     = WR_IDX_W'(i);
      w.wr_j     = WR_IDX_W'(j);
      w.wr_k     = WR_IDX_W'(k);
      w.wr_value = value;
      w.pt_x     = $urandom();   // don't-care fields still toggle
      w.pt_y     = $urandom();
      w.pt_z     = $urandom();
      send_word(w);
   endtask

   // Any corner the sample will touch that was never written gets a value
   // first, so the block never reads an uninitialized entry.
   task automatic sample_at(input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                            input logic [VAL_W-1:0] z);
      grid_word_type w;
      axis_pos_type  px;
      axis_pos_type  py;
      axis_pos_type  pz;
      int            ii;
      int            jj;
      int            kk;
      px = map_axis(0, x);
      py = map_axis(1, y);
      pz = map_axis(2, z);
      for (int dz = 0; dz < 2; dz++) begin
         for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
               ii = dx ? px.hi : px.lo;
               jj = dy ? py.hi : py.lo;
               kk = dz ? pz.hi : pz.lo;
               if (!grid_written[grid_addr(ii, jj, kk)]) begin
                  store_value(ii, jj, kk, rand_value());
               end
            end
         end
      end
      w.func     = FUNC_SAMPLE;
      w.wr_i     = $urandom_range(0, 31);
      w.wr_j     = $urandom_range(0, 31);
      w.wr_k     = $urandom_range(0, 31);
      w.wr_value = $urandom();
      w.pt_x     = x;
      w.pt_y     = y;
      w.pt_z     = z;
      send_word(w);
   endtask

   // ---------------------------------------------------------------------------
   // Register writes, only issued while the block is idle.
   // ---------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      case (idx)
         CSR_ORIGIN_X:      cfg_origin[0] = data;
         CSR_ORIGIN_Y:      cfg_origin[1] = data;
         CSR_ORIGIN_Z:      cfg_origin[2] = data;
         CSR_INV_SPACING_X: cfg_inv[0]    = data[INV_W-1:0];
         CSR_INV_SPACING_Y: cfg_inv[1]    = data[INV_W-1:0];
         CSR_INV_SPACING_Z: cfg_inv[2]    = data[INV_W-1:0];
         CSR_AXIS_SIZES:    cfg_sizes     = data[SIZES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_grid(input logic [VAL_W-1:0] ox, input logic [VAL_W-1:0] oy,
                               input logic [VAL_W-1:0] oz,
                               input logic [CSR_DATA_W-1:0] ix,
                               input logic [CSR_DATA_W-1:0] iy,
                               input logic [CSR_DATA_W-1:0] iz,
                               input logic [SIZES_W-1:0] sizes);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_INV_SPACING_X, ix);
      csr_write(CSR_INV_SPACING_Y, iy);
      csr_write(CSR_INV_SPACING_Z, iz);
      csr_write(CSR_AXIS_SIZES, CSR_DATA_W'(sizes));
   endtask

   // drop valid, wait for every owed sum, then let a sample's worth of cycles pass
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mix: in-grid writes, writes with any 5-bit coordinates, mapped samples, noise;
   // stops early once the word budget is spent
   task automatic random_words(input int count);
      int r;
      repeat (count) begin
         if (words_sent >= WORD_TARGET) break;
         r = $urandom_range(0, 99);
         if (r < 20) begin
            store_value($urandom_range(0, (1 << axis_lg(0)) - 1),
                        $urandom_range(0, (1 << axis_lg(1)) - 1),
                        $urandom_range(0, (1 << axis_lg(2)) - 1), rand_value());
         end else if (r < 27) begin
            store_value($urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom());
         end else if (r < 90) begin
            sample_at(rand_coord(0), rand_coord(1), rand_coord(2));
         end else begin
            sample_at($urandom(), $urandom(), $urandom());
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // registers untouched since reset: 32x32x32 grid, origin 0, unit spacing
   task automatic test_reset_values();
      random_words(6);
      wait_idle();
   endtask

   // 2 x 4 x 1 grid holding the value extremes; writes that fall off the grid
   // (one of them aliasing a real entry if the bounds check were missing),
   // points at the origin, at both ends of the number range, between cells
   // and exactly on a cell boundary. z has size one throughout.
   task automatic test_directed_edges();
      logic [VAL_W-1:0] corner_vals [8];
      corner_vals = '{Q_MAXV, Q_MINV, 32'h0, 32'hFFFF_FFFF,
                      Q_ONE, Q_MAXV, Q_MINV, 32'h1234_5678};
      program_grid('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, 12'h021);
      for (int n = 0; n < 8; n++) begin
         store_value(n % 2, n / 2, 0, corner_vals[n]);
      end
      store_value(2, 0, 0, 32'hDEAD_BEEF);
      store_value(0, 0, 1, 32'hDEAD_BEEF);
      store_value(31, 31, 31, 32'hDEAD_BEEF);
      sample_at('0, '0, '0);
      sample_at(Q_MAXV, Q_MAXV, Q_MAXV);
      sample_at(Q_MINV, Q_MINV, Q_MINV);
      sample_at(32'h0000_8000, 32'h0001_8000, 32'h0001_2345);
      sample_at(Q_ONE, 32'h0003_0000, '0);
      sample_at(Q_MAXV, '0, Q_MINV);
      wait_idle();
   endtask

   // register extremes, each setting followed by a little traffic
   task automatic test_config_extremes();
      // origins at the top, smallest nonzero reciprocal spacing
      program_grid(Q_MAXV, Q_MAXV, Q_MAXV, 32'd1, 32'd1, 32'd1, 12'h333);
      random_words(8);
      wait_idle();
      // origins at the bottom, largest reciprocal, every size field oversize
      program_grid(Q_MINV, Q_MINV, Q_MINV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   12'hFFF);
      random_words(6);
      wait_idle();
      // zero reciprocal spacing pins every axis to its lower corner; all sizes one
      program_grid($urandom(), $urandom(), $urandom(), '0, '0, '0, 12'h000);
      random_words(6);
      wait_idle();
      // mixed axes; bit 31 of a spacing word is dropped by the register
      program_grid(32'hFFFF_0000, 32'h0002_8000, '0, '0, 32'hFFFF_FFFF, Q_ONE, 12'h5A1);
      random_words(8);
      wait_idle();
      // the spare index must leave the setup untouched
      csr_write(CSR_SPARE_IDX, '1);
      random_words(6);
      wait_idle();
   endtask

   // receiver holds off while the sender keeps offering samples, so the
   // output register and the sequencer fill and the request side stalls
   task automatic test_output_stall();
      program_grid('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, 12'h222);
      source_steady = 1'b1;
      hold_off_len  = HOLD_OFF;
      repeat (8) sample_at(rand_coord(0), rand_coord(1), rand_coord(2));
      wait_idle();
      source_steady = 1'b0;
   endtask

   // random settings, each with a burst of random words, until the word budget is spent
   task automatic test_random_traffic();
      logic [VAL_W-1:0]      org [NUM_AXES];
      logic [CSR_DATA_W-1:0] inv [NUM_AXES];
      while (words_sent < WORD_TARGET) begin
         wait_idle();
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            org[ax] = ($urandom_range(0, 7) == 0) ? $urandom() :
                      VAL_W'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
            inv[ax] = ($urandom_range(0, 7) == 0) ? $urandom() :
                      $urandom_range(32'h4000, 32'h4_0000);
         end
         program_grid(org[0], org[1], org[2], inv[0], inv[1], inv[2], rand_sizes());
         source_steady = ($urandom_range(0, 3) == 0);
         sink_steady   = ($urandom_range(0, 3) == 0);
         random_words($urandom_range(30, 60));
      end
      source_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random ready with short and long stalls, or the long
   // hold-off the pressure test asks for, counted here in cycles.
   // ---------------------------------------------------------------------------
   initial begin : sink_side
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (hold_off_len) @(negedge clock);
            hold_off_len   = 0;
            rsp_chan.ready = 1'b1;
         end else if (sink_steady || $urandom_range(0, 2) != 0) begin
            rsp_chan.ready = 1'b1;
         end else begin
            rsp_chan.ready = 1'b0;
            stall = gap_len();
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // every accepted sum is matched against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_samples.size() == 0) begin
            $error("sample_value: expected no word, got %0d (0x%08h)",
                   rsp_chan.sample_value, rsp_chan.sample_value);
            errors++;
         end else begin
            expected_word = pending_samples.pop_front();
            if (rsp_chan.sample_value !== expected_word) begin
               $error("sample_value: expected %0d (0x%08h), got %0d (0x%08h)",
                      expected_word, expected_word,
                      rsp_chan.sample_value, rsp_chan.sample_value);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trilinear_grid_sampler verification failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_WRITE;
      req_chan.write_i     = '0;
      req_chan.write_j     = '0;
      req_chan.write_k     = '0;
      req_chan.write_value = '0;
      req_chan.point_x     = '0;
      req_chan.point_y     = '0;
      req_chan.point_z     = '0;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      errors               = 0;
      words_sent           = 0;
      cycle_count          = 0;
      hold_off_len         = 0;
      source_steady        = 1'b0;
      sink_steady          = 1'b0;
      // register values after reset: origins 0, spacing 1.0, 12'h6DB clamps to 32^3
      cfg_origin = '{default: '0};
      cfg_inv    = '{default: INV_W'(Q_ONE)};
      cfg_sizes  = 12'h6DB;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed_edges();
      test_config_extremes();
      test_output_stall();
      test_random_traffic();

      wait_idle();
      if (errors == 0) begin
         $display("trilinear_grid_sampler verification clean");
      end else begin
         $display("trilinear_grid_sampler verification failed");
      end
      $finish;
   end

endmodule
